FILE: rtl/bzc_pkg.sv
package bzc_pkg;

  localparam int unsigned TableSlots = 8;
  localparam int unsigned RegCount   = 7;
  localparam int unsigned PeriodW    = 8;
  localparam int unsigned NoteW      = 3;
  localparam int unsigned TicksW     = 16;
  localparam int unsigned CfgIdxW    = 3;

  typedef enum logic [2:0] {
    FUNC_TICK        = 3'd0,
    FUNC_START       = 3'd1,
    FUNC_START_ALARM = 3'd2,
    FUNC_STOP        = 3'd3,
    FUNC_STOP_ALARM  = 3'd4,
    FUNC_CHG_NOTE    = 3'd5,
    FUNC_CHG_ON      = 3'd6,
    FUNC_CHG_OFF     = 3'd7
  } func_e;

  typedef logic [TableSlots-1:0][PeriodW-1:0] period_tbl_t;

  // reset periods of the writable entries
  localparam period_tbl_t PeriodReset = {8'd0, 8'd16, 8'd18, 8'd20, 8'd22, 8'd24, 8'd26, 8'd29};

  typedef struct packed {
    logic [NoteW-1:0]  note_index;
    logic [TicksW-1:0] on_ticks;
    logic [TicksW-1:0] off_ticks;
  } cmd_t;

  typedef struct packed {
    logic               tone_enable;
    logic [PeriodW-1:0] tone_top;
    logic [6:0]         tone_compare;
    logic               normal_playing;
    logic               alarm_playing;
  } result_t;

endpackage

FILE: rtl/buzzer_tone_cadence_controller.sv
// Buzzer tone and cadence controller.
//
// Slave stream: one command per transfer. s_axis_tuser carries the command
// code (tick, start, start alarm, stop, stop alarm, change note/on/off);
// s_axis_tdata carries note index and on/off durations in ticks.
// Master stream: one result per command with tone enable, tone top
// (period), tone compare (half period) and the normal and alarm play flags,
// all taken after the command has been applied.
// Config port: cfg_we_i writes note period register cfg_idx_i (0..6) with
// cfg_data_i at the clock edge; indexes past the registers are dropped.
//
// Pipeline: command register, then the state update and table select, then
// the result register. Throughput is one command per cycle while the
// receiver takes results; m_axis_tready back-pressure stalls the pipeline.
// Reset clears the play flags, cadence counters and both pipeline stages
// and reloads the default note periods. When the receiver stalls the result
// register holds, the command register fills, and s_axis_tready drops
// until the master side moves again.
module buzzer_tone_cadence_controller import bzc_pkg::*; #(
  parameter int unsigned NOTE_COUNT = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [2:0] note_index, [18:3] on_ticks, [34:19] off_ticks, [39:35] zero
  input  logic [39:0]        s_axis_tdata,
  // [2:0] func
  input  logic [2:0]         s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [0] tone_enable, [8:1] tone_top, [15:9] tone_compare,
  // [16] normal_playing, [17] alarm_playing, [23:18] zero
  output logic [23:0]        m_axis_tdata,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [PeriodW-1:0] cfg_data_i
);

  logic        cmd_vld_q;
  func_e       func_q;
  cmd_t        cmd_q;
  logic        res_vld_q;
  result_t     res_q;
  result_t     res_d;
  period_tbl_t period_tbl;
  logic        advance;

  // command moves on when the result slot is free or being drained
  assign advance       = cmd_vld_q && (!res_vld_q || m_axis_tready);
  assign s_axis_tready = !cmd_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) cmd_vld_q <= s_axis_tvalid;
      if (advance) begin
        res_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      func_q <= func_e'(s_axis_tuser);
      cmd_q  <= cmd_t'{note_index: s_axis_tdata[2:0],
                       on_ticks:   s_axis_tdata[18:3],
                       off_ticks:  s_axis_tdata[34:19]};
    end
    if (advance) res_q <= res_d;
  end

  bzc_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .period_tbl_o (period_tbl)
  );

  bzc_core #(
    .NOTE_COUNT (NOTE_COUNT)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .func_i       (func_q),
    .cmd_i        (cmd_q),
    .period_tbl_i (period_tbl),
    .result_o     (res_d)
  );

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = {6'd0, res_q.alarm_playing, res_q.normal_playing,
                          res_q.tone_compare, res_q.tone_top, res_q.tone_enable};

endmodule

FILE: rtl/bzc_cfg.sv
module bzc_cfg import bzc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [PeriodW-1:0] cfg_data_i,
  output period_tbl_t        period_tbl_o
);

  period_tbl_t period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
    end else if (cfg_we_i && (32'(cfg_idx_i) < RegCount)) begin
      period_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // slots without a register read zero
  always_comb begin
    period_tbl_o = period_q;
    for (int i = RegCount; i < TableSlots; i++) begin
      period_tbl_o[i] = '0;
    end
  end

endmodule

FILE: rtl/bzc_core.sv
module bzc_core import bzc_pkg::*; #(
  parameter int unsigned NOTE_COUNT = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  func_e       func_i,
  input  cmd_t        cmd_i,
  input  period_tbl_t period_tbl_i,
  output result_t     result_o
);

  localparam logic [NoteW-1:0] NoteMax =
      (NOTE_COUNT - 1 > TableSlots - 1) ? NoteW'(TableSlots - 1) : NoteW'(NOTE_COUNT - 1);

  logic               normal_q, normal_d;
  logic               alarm_q, alarm_d;
  logic               running_q, running_d;
  logic [TicksW-1:0]  on_rem_q, on_rem_d;
  logic [TicksW-1:0]  off_rem_q, off_rem_d;
  logic [TicksW-1:0]  on_dur_q, on_dur_d;
  logic [TicksW-1:0]  off_dur_q, off_dur_d;
  logic               out_on_q, out_on_d;
  logic [PeriodW-1:0] period_q, period_d;

  logic [NoteW-1:0]   note_sel;
  logic [PeriodW-1:0] note_period;
  logic               normal_ok;
  logic               active;
  logic [TicksW-1:0]  on_dec;

  assign note_sel    = (cmd_i.note_index > NoteMax) ? NoteMax : cmd_i.note_index;
  assign note_period = period_tbl_i[note_sel];
  assign normal_ok   = !alarm_q && normal_q;
  assign active      = normal_q || alarm_q;

  always_comb begin
    normal_d  = normal_q;
    alarm_d   = alarm_q;
    running_d = running_q;
    on_rem_d  = on_rem_q;
    off_rem_d = off_rem_q;
    on_dur_d  = on_dur_q;
    off_dur_d = off_dur_q;
    out_on_d  = out_on_q;
    period_d  = period_q;
    on_dec    = '0;
    case (func_i)
      FUNC_TICK: begin
        if (!running_q) begin
          if (active) begin
            running_d = 1'b1;
            on_dec    = on_dur_q - 1'b1;   // zero on-time wraps
            on_rem_d  = on_dec;
            off_rem_d = off_dur_q;
            if (on_dec == '0) out_on_d = 1'b0;
          end
        end else if (active) begin
          if (on_rem_q != '0) begin
            on_dec   = on_rem_q - 1'b1;
            on_rem_d = on_dec;
            if (on_dec == '0) out_on_d = 1'b0;
          end else if (off_rem_q != '0) begin
            off_rem_d = off_rem_q - 1'b1;
          end else begin
            out_on_d  = 1'b1;
            on_rem_d  = on_dur_q;
            off_rem_d = off_dur_q;
          end
        end else begin
          running_d = 1'b0;
        end
      end
      FUNC_START: begin
        if (!alarm_q && !normal_q) begin
          period_d  = note_period;
          on_dur_d  = cmd_i.on_ticks;
          off_dur_d = cmd_i.off_ticks;
          out_on_d  = 1'b1;
          normal_d  = 1'b1;
        end
      end
      FUNC_START_ALARM: begin
        // alarm preempts any normal tone
        if (!alarm_q) normal_d = 1'b0;
        period_d  = note_period;
        on_dur_d  = cmd_i.on_ticks;
        off_dur_d = cmd_i.off_ticks;
        out_on_d  = 1'b1;
        alarm_d   = 1'b1;
      end
      FUNC_STOP: begin
        if (normal_ok) begin
          out_on_d = 1'b0;
          normal_d = 1'b0;
        end
      end
      FUNC_STOP_ALARM: begin
        if (alarm_q) begin
          out_on_d = 1'b0;
          alarm_d  = 1'b0;
        end
      end
      FUNC_CHG_NOTE: begin
        if (normal_ok) period_d = note_period;
      end
      FUNC_CHG_ON: begin
        if (normal_ok) on_dur_d = cmd_i.on_ticks;
      end
      FUNC_CHG_OFF: begin
        if (normal_ok) off_dur_d = cmd_i.off_ticks;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q  <= 1'b0;
      alarm_q   <= 1'b0;
      running_q <= 1'b0;
      on_rem_q  <= '0;
      off_rem_q <= '0;
      on_dur_q  <= TicksW'(1);
      off_dur_q <= TicksW'(1);
      out_on_q  <= 1'b0;
      period_q  <= '0;
    end else if (en_i) begin
      normal_q  <= normal_d;
      alarm_q   <= alarm_d;
      running_q <= running_d;
      on_rem_q  <= on_rem_d;
      off_rem_q <= off_rem_d;
      on_dur_q  <= on_dur_d;
      off_dur_q <= off_dur_d;
      out_on_q  <= out_on_d;
      period_q  <= period_d;
    end
  end

  assign result_o.tone_enable    = out_on_d;
  assign result_o.tone_top       = period_d;
  assign result_o.tone_compare   = period_d[PeriodW-1:1];
  assign result_o.normal_playing = normal_d;
  assign result_o.alarm_playing  = alarm_d;

endmodule
